// ----- src/bhe_pkg.sv -----
// shared types, constants and codes of the binned histogram engine
// no dependencies; used by bhe_ctrl, bhe_datapath and the top level
package bhe_pkg;

   localparam int CELL_COUNT  = 1024;
   localparam int COUNT_WIDTH = 32;
   localparam int ADDR_WIDTH  = $clog2(CELL_COUNT);
   localparam int CELLS_WIDTH = ($clog2(CELL_COUNT + 1) > 11) ? $clog2(CELL_COUNT + 1) : 11;

   localparam int BIN_CAP_LIMIT = 1022;
   localparam int BIN_CAP       = 1023;
   localparam int CSR_COUNT_W   = 3;

   typedef logic signed [COUNT_WIDTH-1:0] cnt_type;

   typedef enum logic [2:0] {
      FUNC_FILL   = 3'd0,
      FUNC_ADD    = 3'd1,
      FUNC_SET    = 3'd2,
      FUNC_READ   = 3'd3,
      FUNC_MAX    = 3'd4,
      FUNC_CENTRE = 3'd5,
      FUNC_CLEAR  = 3'd6
   } func_type;

   typedef enum logic [1:0] {
      STATUS_DONE    = 2'd0,
      STATUS_RANGE   = 2'd1,
      STATUS_IGNORED = 2'd2
   } status_type;

   typedef enum logic [CSR_COUNT_W-1:0] {
      CSR_RANGE_LOW  = 3'd0,
      CSR_RANGE_HIGH = 3'd1,
      CSR_BIN_COUNT  = 3'd2,
      CSR_BIN_SCALE  = 3'd3,
      CSR_BIN_WIDTH  = 3'd4,
      CSR_THRESHOLD  = 3'd5
   } csr_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic fetch;
      logic update;
      logic scan;
      logic clear_write;
   } cmd_type;

   typedef struct packed {
      logic [2:0] func;
      logic       sweep_at_end;
      logic       scan_at_end;
   } stat_type;

endpackage

// ----- src/bhe_ctrl.sv -----
// sequencer of the binned histogram engine: state, busy and response strobe
// depends on bhe_pkg; drives the command word of bhe_datapath
module bhe_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [2:0]         req_func,
   input  bhe_pkg::stat_type  stat,
   output bhe_pkg::cmd_type   cmd,
   output logic               busy,
   output logic               rsp_valid
);

   typedef enum logic [2:0] {
      S_INIT,
      S_IDLE,
      S_MUL,
      S_FETCH,
      S_UPDATE,
      S_SCAN,
      S_DRAIN,
      S_CLEAR
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff;
   logic      rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_INIT: begin
            cmd.clear_write = 1'b1;
            if (stat.sweep_at_end) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               unique case (bhe_pkg::func_type'(req_func))
                  bhe_pkg::FUNC_FILL,
                  bhe_pkg::FUNC_CENTRE: state_in = S_MUL;
                  bhe_pkg::FUNC_MAX:    state_in = S_SCAN;
                  bhe_pkg::FUNC_CLEAR:  state_in = S_CLEAR;
                  default:              state_in = S_UPDATE;
               endcase
            end
         end
         S_MUL: begin
            cmd.mul = 1'b1;
            if (stat.func == bhe_pkg::FUNC_FILL) state_in = S_FETCH;
            else state_in = S_UPDATE;
         end
         S_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = S_UPDATE;
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = S_IDLE;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (stat.scan_at_end) state_in = S_DRAIN;
         end
         S_DRAIN: begin
            state_in = S_UPDATE;
         end
         S_CLEAR: begin
            cmd.clear_write = 1'b1;
            if (stat.sweep_at_end) state_in = S_UPDATE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         busy_ff      <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         busy_ff      <= (state_in != S_IDLE);
         rsp_valid_ff <= (state_ff == S_UPDATE);
      end
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- src/bhe_datapath.sv -----
// datapath of the binned histogram engine: csr bank, bin memory, multiplier,
// sweep counter, maximum search and response registers; depends on bhe_pkg
module bhe_datapath (
   input  logic                     clock,
   input  logic                     reset,
   input  bhe_pkg::cmd_type         cmd,
   output bhe_pkg::stat_type        stat,
   input  logic                     csr_write_enable,
   input  logic [2:0]               csr_index,
   input  logic [31:0]              csr_write_data,
   input  logic [2:0]               req_func,
   input  logic signed [31:0]       req_coordinate,
   input  logic signed [31:0]       req_weight,
   input  logic [9:0]               req_bin_index,
   input  logic signed [31:0]       req_new_value,
   output logic [1:0]               rsp_status,
   output logic [9:0]               rsp_result_bin,
   output logic signed [31:0]       rsp_content,
   output logic signed [31:0]       rsp_centre,
   output logic [31:0]              rsp_entries
);

   localparam int AW = bhe_pkg::ADDR_WIDTH;
   localparam int CW = bhe_pkg::CELLS_WIDTH;

   // csr bank
   logic signed [31:0] range_low_ff, range_high_ff, read_threshold_ff;
   logic [9:0]         bin_count_ff;
   logic [31:0]        bin_scale_ff, bin_width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         range_low_ff      <= '0;
         range_high_ff     <= '0;
         bin_count_ff      <= 10'd1;
         bin_scale_ff      <= '0;
         bin_width_ff      <= '0;
         read_threshold_ff <= '0;
      end else if (csr_write_enable) begin
         unique case (bhe_pkg::csr_type'(csr_index))
            bhe_pkg::CSR_RANGE_LOW:  range_low_ff      <= $signed(csr_write_data);
            bhe_pkg::CSR_RANGE_HIGH: range_high_ff     <= $signed(csr_write_data);
            bhe_pkg::CSR_BIN_COUNT:  bin_count_ff      <= csr_write_data[9:0];
            bhe_pkg::CSR_BIN_SCALE:  bin_scale_ff      <= csr_write_data;
            bhe_pkg::CSR_BIN_WIDTH:  bin_width_ff      <= csr_write_data;
            bhe_pkg::CSR_THRESHOLD:  read_threshold_ff <= $signed(csr_write_data);
            default: ;
         endcase
      end
   end

   // number of live cells
   logic [CW-1:0] cell_sum, cells;
   always_comb begin
      cell_sum = CW'(bin_count_ff) + CW'(2);
      cells    = (cell_sum > CW'(bhe_pkg::CELL_COUNT)) ? CW'(bhe_pkg::CELL_COUNT) : cell_sum;
   end

   // latched request word
   logic [2:0]         func_ff;
   logic [9:0]         bin_ff, bin_in;
   logic signed [31:0] weight_ff, new_value_ff;
   logic               in_range_ff;
   logic [31:0]        opa_ff, opb_ff;
   logic [63:0]        prod_ff;

   // fill bin from the registered product
   logic [31:0] quot;
   logic [9:0]  fill_bin;
   always_comb begin
      quot = prod_ff[63:32];
      if (!in_range_ff) fill_bin = '0;
      else if (quot >= 32'(bhe_pkg::BIN_CAP_LIMIT)) fill_bin = 10'(bhe_pkg::BIN_CAP);
      else fill_bin = quot[9:0] + 10'd1;
   end

   always_comb begin
      bin_in = bin_ff;
      if (cmd.load) bin_in = req_bin_index;
      else if (cmd.fetch) bin_in = fill_bin;
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      if (cmd.load) begin
         func_ff      <= req_func;
         weight_ff    <= req_weight;
         new_value_ff <= req_new_value;
         in_range_ff  <= (req_coordinate >= range_low_ff) && (req_coordinate <= range_high_ff);
         if (req_func == bhe_pkg::FUNC_FILL) begin
            opa_ff <= $unsigned(req_coordinate) - $unsigned(range_low_ff);
            opb_ff <= bin_scale_ff;
         end else begin
            opa_ff <= 32'(req_bin_index) - 32'd1;
            opb_ff <= bin_width_ff;
         end
      end
      if (cmd.mul) prod_ff <= 64'(opa_ff) * 64'(opb_ff);
   end

   // sweep counter for clear and maximum search
   logic [AW-1:0] sweep_ff;
   always_ff @(posedge clock) begin
      if (reset || cmd.load) sweep_ff <= '0;
      else if (cmd.scan || cmd.clear_write) sweep_ff <= sweep_ff + AW'(1);
   end

   // update decisions
   logic       out_of_range;
   logic       cell_ok;
   logic       do_write;
   logic [AW-1:0] waddr, raddr;
   bhe_pkg::cnt_type wdata;
   bhe_pkg::cnt_type rdata_ff;

   assign out_of_range = (CW'(bin_ff) >= cells);
   assign cell_ok      = !out_of_range && (bin_ff != '0);

   always_comb begin
      do_write = 1'b0;
      waddr    = AW'(bin_ff);
      wdata    = rdata_ff + bhe_pkg::COUNT_WIDTH'(weight_ff);
      if (cmd.clear_write) begin
         do_write = 1'b1;
         waddr    = sweep_ff;
         wdata    = '0;
      end else if (cmd.update && cell_ok) begin
         unique case (func_ff)
            bhe_pkg::FUNC_FILL,
            bhe_pkg::FUNC_ADD: do_write = 1'b1;
            bhe_pkg::FUNC_SET: begin
               do_write = 1'b1;
               wdata    = bhe_pkg::COUNT_WIDTH'(new_value_ff);
            end
            default: do_write = 1'b0;
         endcase
      end
   end

   always_comb begin
      if (cmd.load) raddr = AW'(req_bin_index);
      else if (cmd.fetch) raddr = AW'(fill_bin);
      else raddr = sweep_ff;
   end

   // bin memory
   bhe_pkg::cnt_type bin_mem [bhe_pkg::CELL_COUNT];
   always_ff @(posedge clock) begin
      if (do_write) bin_mem[waddr] <= wdata;
      rdata_ff <= bin_mem[raddr];
   end

   // maximum search
   logic             cmp_valid_ff;
   logic [AW-1:0]    cmp_idx_ff;
   bhe_pkg::cnt_type best_ff;
   logic [AW-1:0]    best_bin_ff;

   always_ff @(posedge clock) begin
      if (reset) cmp_valid_ff <= 1'b0;
      else cmp_valid_ff <= cmd.scan;
      cmp_idx_ff <= sweep_ff;
      if (cmd.load) begin
         best_ff     <= '0;
         best_bin_ff <= '0;
      end else if (cmp_valid_ff && (rdata_ff > best_ff)) begin
         best_ff     <= rdata_ff;
         best_bin_ff <= cmp_idx_ff;
      end
   end

   // entry counter
   logic [31:0] entry_ff, entry_in;
   always_comb begin
      entry_in = entry_ff;
      if (cmd.update) begin
         if (func_ff == bhe_pkg::FUNC_CLEAR) entry_in = '0;
         else if (cell_ok && (func_ff == bhe_pkg::FUNC_FILL || func_ff == bhe_pkg::FUNC_ADD))
            entry_in = entry_ff + 32'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) entry_ff <= '0;
      else entry_ff <= entry_in;
   end

   // response word
   logic [1:0]         status_in;
   logic [9:0]         rbin_in;
   logic signed [31:0] content_in;
   logic [31:0]        centre_in;

   always_comb begin
      status_in  = bhe_pkg::STATUS_DONE;
      rbin_in    = '0;
      content_in = '0;
      centre_in  = '0;
      unique case (func_ff)
         bhe_pkg::FUNC_FILL,
         bhe_pkg::FUNC_ADD,
         bhe_pkg::FUNC_SET: begin
            if (out_of_range) status_in = bhe_pkg::STATUS_RANGE;
            else if (bin_ff == '0) status_in = bhe_pkg::STATUS_IGNORED;
            if (func_ff == bhe_pkg::FUNC_FILL) rbin_in = bin_ff;
         end
         bhe_pkg::FUNC_READ: begin
            if (out_of_range) status_in = bhe_pkg::STATUS_RANGE;
            else if (rdata_ff >= read_threshold_ff) content_in = 32'(rdata_ff);
         end
         bhe_pkg::FUNC_MAX: begin
            rbin_in    = 10'(best_bin_ff);
            content_in = 32'(best_ff);
         end
         bhe_pkg::FUNC_CENTRE: begin
            centre_in = $unsigned(range_low_ff) + prod_ff[31:0] + (bin_width_ff >> 1);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         rsp_status     <= status_in;
         rsp_result_bin <= rbin_in;
         rsp_content    <= content_in;
         rsp_centre     <= $signed(centre_in);
         rsp_entries    <= entry_in;
      end
   end

   assign stat.func         = func_ff;
   assign stat.sweep_at_end = (sweep_ff == AW'(bhe_pkg::CELL_COUNT - 1));
   assign stat.scan_at_end  = (CW'(sweep_ff) == cells - CW'(1));

endmodule

// ----- src/binned_histogram_engine_top.sv -----
// binned histogram engine: a word is taken when start is high and busy low,
// one response word follows as a single-cycle rsp_valid strobe, no stall.
// path to the strobe: add, set, read, unused code 7 go straight to update; centre multiplies;
// fill multiplies, then does a memory read-modify-write; maximum scans, drains; clear sweeps.
// a new word can be taken in the strobe cycle.
// synchronous reset clears the csr bank and runs a memory clear of all CELL_COUNT cells, busy high.
module binned_histogram_engine_top (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [2:0]         req_func,
   input  logic signed [31:0] req_coordinate,
   input  logic signed [31:0] req_weight,
   input  logic [9:0]         req_bin_index,
   input  logic signed [31:0] req_new_value,
   output logic               rsp_valid,
   output logic [1:0]         rsp_status,
   output logic [9:0]         rsp_result_bin,
   output logic signed [31:0] rsp_content,
   output logic signed [31:0] rsp_centre,
   output logic [31:0]        rsp_entries,
   input  logic               csr_write_enable,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_write_data
);

   bhe_pkg::cmd_type  cmd;
   bhe_pkg::stat_type stat;

   bhe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_func  (req_func),
      .stat      (stat),
      .cmd       (cmd),
      .busy      (busy),
      .rsp_valid (rsp_valid)
   );

   bhe_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_func         (req_func),
      .req_coordinate   (req_coordinate),
      .req_weight       (req_weight),
      .req_bin_index    (req_bin_index),
      .req_new_value    (req_new_value),
      .rsp_status       (rsp_status),
      .rsp_result_bin   (rsp_result_bin),
      .rsp_content      (rsp_content),
      .rsp_centre       (rsp_centre),
      .rsp_entries      (rsp_entries)
   );

endmodule
